/* sv/adfd_pkg.sv */
// ---------------------------------------------------------------------------
// adfd_pkg: shared definitions for the framed 4-bit ADPCM decoder
// Register indexes, coding types, configuration struct and the fixed
// predictor coefficient table.
// ---------------------------------------------------------------------------
package adfd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_SIZE       = 3'd0;
    localparam logic [2:0] REG_CODING_TYPE      = 3'd1;
    localparam logic [2:0] REG_EXACT_PREDICTION = 3'd2;
    localparam logic [2:0] REG_START_HISTORY    = 3'd3;
    localparam logic [2:0] REG_SAMPLE_COUNT     = 3'd4;
    localparam logic [2:0] REG_SKIP_COUNT       = 3'd5;
    localparam logic [2:0] REG_COEF_FIRST       = 3'd6;
    localparam logic [2:0] REG_COEF_SECOND      = 3'd7;

    // Coding types
    localparam logic [1:0] CODING_FIXED  = 2'd0;
    localparam logic [1:0] CODING_LINEAR = 2'd1;
    localparam logic [1:0] CODING_EXP    = 2'd2;

    // Framing and header constants
    localparam logic [7:0]  MIN_FRAME_SIZE  = 8'd3;
    localparam logic [7:0]  HEADER_BYTES    = 8'd2;
    localparam logic [12:0] EXP_FIELD_MAX   = 13'd12;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_FRAME_SIZE  = 8'd18;
    localparam logic [1:0] RST_CODING_TYPE = CODING_LINEAR;

    typedef struct packed {
        logic [7:0]  frame_size;
        logic [1:0]  coding_type;
        logic        exact_prediction;
        logic [15:0] start_history;
        logic [31:0] sample_count;
        logic [31:0] skip_count;
        logic [15:0] coef_first;
        logic [15:0] coef_second;
    } t_cfg;

    // Fixed predictor table, 4.12 format; tap 0 weighs the recent sample
    function automatic logic [15:0] fixed_coef(input logic [1:0] row, input logic tap);
        logic [15:0] c;
        case (row)
            2'd0:    c = 16'h0000;
            2'd1:    c = tap ? 16'h0000 : 16'h0f00;
            2'd2:    c = tap ? 16'hf300 : 16'h1cc0;
            2'd3:    c = tap ? 16'hf240 : 16'h1880;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

endpackage

/* sv/adfd_cfg_regs.sv */
// ---------------------------------------------------------------------------
// adfd_cfg_regs: configuration register file
// Takes register write transactions and flags a history reload on a write
// to the start history register.
// ---------------------------------------------------------------------------
module adfd_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_cfg_ready,
    output adfd_pkg::t_cfg      o_cfg,
    output logic                o_hist_load
);

    adfd_pkg::t_cfg r_cfg;
    adfd_pkg::t_cfg n_cfg;
    logic           wr;

    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid && o_cfg_ready;
    assign o_hist_load = wr && (i_cfg_index == adfd_pkg::REG_START_HISTORY);
    assign o_cfg       = r_cfg;

    // Decode the write transaction
    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            case (i_cfg_index)
                adfd_pkg::REG_FRAME_SIZE:       n_cfg.frame_size       = i_cfg_data[7:0];
                adfd_pkg::REG_CODING_TYPE:      n_cfg.coding_type      = i_cfg_data[1:0];
                adfd_pkg::REG_EXACT_PREDICTION: n_cfg.exact_prediction = i_cfg_data[0];
                adfd_pkg::REG_START_HISTORY:    n_cfg.start_history    = i_cfg_data[15:0];
                adfd_pkg::REG_SAMPLE_COUNT:     n_cfg.sample_count     = i_cfg_data;
                adfd_pkg::REG_SKIP_COUNT:       n_cfg.skip_count       = i_cfg_data;
                adfd_pkg::REG_COEF_FIRST:       n_cfg.coef_first       = i_cfg_data[15:0];
                adfd_pkg::REG_COEF_SECOND:      n_cfg.coef_second      = i_cfg_data[15:0];
                default:                        n_cfg                  = r_cfg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_size       <= adfd_pkg::RST_FRAME_SIZE;
            r_cfg.coding_type      <= adfd_pkg::RST_CODING_TYPE;
            r_cfg.exact_prediction <= 1'b1;
            r_cfg.start_history    <= 16'd0;
            r_cfg.sample_count     <= 32'd0;
            r_cfg.skip_count       <= 32'd0;
            r_cfg.coef_first       <= 16'd0;
            r_cfg.coef_second      <= 16'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* sv/adfd_nibble_dp.sv */
// ---------------------------------------------------------------------------
// adfd_nibble_dp: single-nibble decode datapath
// Two-tap prediction in 4.12 format, gain times code, sum and clamp to
// signed 16 bits.
// ---------------------------------------------------------------------------
module adfd_nibble_dp (
    input  logic [13:0]        i_gain,
    input  logic signed [15:0] i_hist_recent,
    input  logic signed [15:0] i_hist_older,
    input  logic signed [15:0] i_coef_first,
    input  logic signed [15:0] i_coef_second,
    input  logic [3:0]         i_code,
    input  logic               i_exact,
    output logic signed [15:0] o_sample
);

    logic signed [31:0] prod1;
    logic signed [31:0] prod2;
    logic signed [32:0] prod_sum;
    logic signed [20:0] pred_exact;
    logic signed [20:0] pred_split;
    logic signed [20:0] pred;
    logic signed [18:0] step;
    logic signed [22:0] value;

    // Tap products
    assign prod1 = i_hist_recent * i_coef_first;
    assign prod2 = i_hist_older * i_coef_second;

    // Floor shift either once on the sum or on each tap
    assign prod_sum   = $signed({prod1[31], prod1}) + $signed({prod2[31], prod2});
    assign pred_exact = $signed(prod_sum[32:12]);
    assign pred_split = $signed({prod1[31], prod1[31:12]}) + $signed({prod2[31], prod2[31:12]});
    assign pred       = i_exact ? pred_exact : pred_split;

    // Scaled code
    assign step = $signed({1'b0, i_gain}) * $signed(i_code);

    assign value = $signed({{2{pred[20]}}, pred}) + $signed({{4{step[18]}}, step});

    // Clamp to the sample range
    always_comb begin
        if (value > 23'sd32767) begin
            o_sample = 16'sh7fff;
        end else if (value < -23'sd32768) begin
            o_sample = 16'sh8000;
        end else begin
            o_sample = value[15:0];
        end
    end

endmodule

/* sv/adpcm_4bit_frame_decoder.sv */
// ---------------------------------------------------------------------------
// adpcm_4bit_frame_decoder: framed 4-bit ADPCM decoder, top level
// Parses two-byte frame headers and decodes two nibbles per data byte.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------
//  input    | in        | i_in_valid / o_in_stall    | i_data_byte
//  output   | out       | o_out_valid / i_out_stall  | o_pcm_sample, o_last_of_byte
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Header bytes are captured whole; data bytes are decoded one nibble at a time,
//  as set by the history feedback through the prediction multipliers.
//  An output register parts the sides; the next byte enters as the last one ends.
//  An output stall holds the nibble that has a sample to deliver.
//  Reset is synchronous, active low, and clears framing, counters and history.
// ---------------------------------------------------------------------------
module adpcm_4bit_frame_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_pcm_sample,
    output logic               o_last_of_byte,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    adfd_pkg::t_cfg     cfg;
    logic               hist_load;

    logic               r_busy, n_busy;
    logic [7:0]         r_byte, n_byte;
    logic               r_phase, n_phase;
    logic [7:0]         r_bif, n_bif;
    logic [7:0]         r_hdr, n_hdr;
    logic [13:0]        r_gain, n_gain;
    logic [2:0]         r_psel, n_psel;
    logic signed [15:0] r_h1, n_h1;
    logic signed [15:0] r_h2, n_h2;
    logic [31:0]        r_pos, n_pos;
    logic [31:0]        r_emit, n_emit;
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_out_sample, n_out_sample;
    logic               r_out_last, n_out_last;

    logic               is_data;
    logic               emits;
    logic               out_free;
    logic               advance;
    logic               done;
    logic               in_accept;
    logic               last_hi;
    logic               frame_end;
    logic [7:0]         frame_len;
    logic [12:0]        field;
    logic [13:0]        hdr_gain;
    logic [3:0]         code;
    logic [15:0]        coef1;
    logic [15:0]        coef2;
    logic signed [15:0] dp_sample;

    adfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg),
        .o_hist_load (hist_load)
    );

    // Select coefficients for this frame
    always_comb begin
        if (cfg.coding_type == adfd_pkg::CODING_FIXED) begin
            coef1 = adfd_pkg::fixed_coef(r_psel[1:0], 1'b0);
            coef2 = adfd_pkg::fixed_coef(r_psel[1:0], 1'b1);
        end else begin
            coef1 = cfg.coef_first;
            coef2 = cfg.coef_second;
        end
    end

    assign code = r_phase ? r_byte[3:0] : r_byte[7:4];

    adfd_nibble_dp u_dp (
        .i_gain        (r_gain),
        .i_hist_recent (r_h1),
        .i_hist_older  (r_h2),
        .i_coef_first  ($signed(coef1)),
        .i_coef_second ($signed(coef2)),
        .i_code        (code),
        .i_exact       (cfg.exact_prediction),
        .o_sample      (dp_sample)
    );

    // Header gain from the 13-bit scale field
    assign field = {r_hdr[4:0], r_byte};
    always_comb begin
        if (cfg.coding_type == adfd_pkg::CODING_EXP) begin
            if (field > adfd_pkg::EXP_FIELD_MAX) begin
                hdr_gain = 14'd1;
            end else begin
                hdr_gain = 14'd1 << (adfd_pkg::EXP_FIELD_MAX[3:0] - field[3:0]);
            end
        end else begin
            hdr_gain = {1'b0, field} + 14'd1;
        end
    end

    // Flow control
    assign frame_len = (cfg.frame_size < adfd_pkg::MIN_FRAME_SIZE) ?
                       adfd_pkg::MIN_FRAME_SIZE : cfg.frame_size;
    assign frame_end = ({1'b0, r_bif} + 9'd1) >= {1'b0, frame_len};
    assign is_data   = (r_bif >= adfd_pkg::HEADER_BYTES);
    assign emits     = is_data && !(r_pos < cfg.skip_count) && (r_emit < cfg.sample_count);
    assign last_hi   = ({1'b0, r_emit} + 33'd1) == {1'b0, cfg.sample_count};
    assign out_free  = !r_out_valid || !i_out_stall;
    assign advance   = r_busy && (!emits || out_free);
    assign done      = advance && (!is_data || r_phase);
    assign o_in_stall = r_busy && !done;
    assign in_accept = i_in_valid && !o_in_stall;

    // Next state
    always_comb begin
        n_busy       = r_busy;
        n_byte       = r_byte;
        n_phase      = r_phase;
        n_bif        = r_bif;
        n_hdr        = r_hdr;
        n_gain       = r_gain;
        n_psel       = r_psel;
        n_h1         = r_h1;
        n_h2         = r_h2;
        n_pos        = r_pos;
        n_emit       = r_emit;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;

        // Advance one nibble
        if (advance && is_data) begin
            n_phase = !r_phase;
            n_pos   = (r_pos == 32'hffff_ffff) ? r_pos : r_pos + 32'd1;
            if (emits) begin
                n_h2   = r_h1;
                n_h1   = dp_sample;
                n_emit = r_emit + 32'd1;
            end
        end

        // Capture header bytes
        if (advance && !is_data) begin
            if (r_bif == 8'd0) begin
                n_hdr = r_byte;
            end else begin
                n_psel = r_hdr[7:5];
                n_gain = hdr_gain;
            end
        end

        if (done) begin
            n_bif = frame_end ? 8'd0 : r_bif + 8'd1;
        end

        // Load both history samples with the value being written
        if (hist_load) begin
            n_h1 = $signed(i_cfg_data[15:0]);
            n_h2 = $signed(i_cfg_data[15:0]);
        end

        // Load or drain the output register
        if (out_free) begin
            n_out_valid  = advance && emits;
            n_out_sample = dp_sample;
            n_out_last   = r_phase || last_hi;
        end

        if (in_accept) begin
            n_busy = 1'b1;
            n_byte = i_data_byte;
        end else if (done) begin
            n_busy = 1'b0;
        end
    end

    // Control and history registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= 1'b0;
            r_bif       <= 8'd0;
            r_hdr       <= 8'd0;
            r_gain      <= 14'd0;
            r_psel      <= 3'd0;
            r_h1        <= 16'sd0;
            r_h2        <= 16'sd0;
            r_pos       <= 32'd0;
            r_emit      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_bif       <= n_bif;
            r_hdr       <= n_hdr;
            r_gain      <= n_gain;
            r_psel      <= n_psel;
            r_h1        <= n_h1;
            r_h2        <= n_h2;
            r_pos       <= n_pos;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_pcm_sample   = r_out_sample;
    assign o_last_of_byte = r_out_last;

endmodule

/* sv/adfd_checker.sv */
// ---------------------------------------------------------------------------
// adfd_checker: port-level checks for the ADPCM frame decoder
// Watches the top-level handshakes over time; bound to the top level.
// ---------------------------------------------------------------------------
module adfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_pcm_sample,
    input logic        o_last_of_byte
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_pcm_sample) && $stable(o_last_of_byte))
        else $error("stalled output transaction changed");

    // Reset drops the output and frees the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // With the output register free, a byte is finished by the next cycle
    // unless the sample just produced is held by the consumer
    a_byte_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !o_out_valid |=> !o_in_stall || (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind adpcm_4bit_frame_decoder adfd_checker u_adfd_checker (.*);

/* dv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the framed 4-bit ADPCM decoder
// A queue-fed driver sends stream bytes with random gaps and a monitor
// predicts the decoded samples of every accepted byte. Each delivered
// sample is checked against the oldest prediction. Phases with different
// register settings are separated by idle periods.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int          RANDOM_ITEMS  = 450;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam logic [1:0]  CODING_UNUSED = 2'd3;

    // Fixed predictor table, 4.12 format
    localparam logic signed [15:0] ROW1_RECENT = 16'sh0f00;
    localparam logic signed [15:0] ROW2_RECENT = 16'sh1cc0;
    localparam logic signed [15:0] ROW2_OLDER  = 16'shf300;
    localparam logic signed [15:0] ROW3_RECENT = 16'sh1880;
    localparam logic signed [15:0] ROW3_OLDER  = 16'shf240;

    typedef struct packed {
        logic signed [15:0] pcm;
        logic               last;
    } t_pcm_result;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_data_byte    = 8'h00;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic signed [15:0] o_pcm_sample;
    logic               o_last_of_byte;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index    = 3'd0;
    logic [31:0]        i_cfg_data     = 32'd0;

    // Register copies, at their reset values
    logic [7:0]         cfg_frame_size   = adfd_pkg::RST_FRAME_SIZE;
    logic [1:0]         cfg_coding_type  = adfd_pkg::RST_CODING_TYPE;
    logic               cfg_exact        = 1'b1;
    logic [31:0]        cfg_sample_count = 32'd0;
    logic [31:0]        cfg_skip_count   = 32'd0;
    logic signed [15:0] cfg_coef_first   = 16'sd0;
    logic signed [15:0] cfg_coef_second  = 16'sd0;

    // Decoder state copies
    int                 frame_pos    = 0;
    logic [7:0]         hdr_byte     = 8'h00;
    logic [13:0]        frame_gain   = 14'd0;
    logic [2:0]         pred_sel     = 3'd0;
    logic signed [15:0] hist_recent  = 16'sd0;
    logic signed [15:0] hist_older   = 16'sd0;
    logic [31:0]        stream_pos   = 32'd0;
    logic [31:0]        emitted_cnt  = 32'd0;

    t_pcm_result        pcm_expected [$];
    logic [7:0]         byte_queue   [$];

    bit                 in_fire      = 1'b0;
    bit                 idle_on      = 1'b1;
    int                 sent_count   = 0;
    int                 drain_at     = -1;
    int                 in_gap       = 0;
    int                 out_hold     = 0;
    int                 error_count  = 0;
    int                 cycle_count  = 0;

    adpcm_4bit_frame_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pcm_sample   (o_pcm_sample),
        .o_last_of_byte (o_last_of_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock generation
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Decode one nibble; padding and the sample limit leave history alone
    task automatic decode_nibble(input logic [3:0] code, output bit made,
                                 output logic signed [15:0] smp);
        logic signed [15:0] c1, c2;
        longint             pred, v;
        int                 s;
        made = 1'b0;
        smp  = 16'sd0;
        if (stream_pos < cfg_skip_count) begin
            stream_pos++;
        end else begin
            if (stream_pos != 32'hFFFF_FFFF) stream_pos++;
            if (emitted_cnt < cfg_sample_count) begin
                if (cfg_coding_type == adfd_pkg::CODING_FIXED) begin
                    case (pred_sel[1:0])
                        2'd1:    begin c1 = ROW1_RECENT; c2 = 16'sd0;     end
                        2'd2:    begin c1 = ROW2_RECENT; c2 = ROW2_OLDER; end
                        2'd3:    begin c1 = ROW3_RECENT; c2 = ROW3_OLDER; end
                        default: begin c1 = 16'sd0;      c2 = 16'sd0;     end
                    endcase
                end else begin
                    c1 = cfg_coef_first;
                    c2 = cfg_coef_second;
                end
                s = int'($signed(code));
                if (cfg_exact)
                    pred = (longint'(hist_recent) * longint'(c1)
                            + longint'(hist_older) * longint'(c2)) >>> 12;
                else
                    pred = ((longint'(hist_recent) * longint'(c1)) >>> 12)
                           + ((longint'(hist_older) * longint'(c2)) >>> 12);
                v = longint'(frame_gain) * s + pred;
                if (v > 32767) v = 32767;
                else if (v < -32768) v = -32768;
                hist_older  = hist_recent;
                hist_recent = v[15:0];
                emitted_cnt++;
                made = 1'b1;
                smp  = v[15:0];
            end
        end
    endtask

    // Advance the framing by one byte and queue the samples it yields
    task automatic predict_byte(input logic [7:0] b);
        int                 fs;
        logic [12:0]        field;
        bit                 made_hi, made_lo;
        logic signed [15:0] s_hi, s_lo;
        t_pcm_result        res;
        fs = (cfg_frame_size < adfd_pkg::MIN_FRAME_SIZE) ?
             adfd_pkg::MIN_FRAME_SIZE : cfg_frame_size;
        if (frame_pos == 0) begin
            hdr_byte = b;
        end else if (frame_pos == 1) begin
            field    = {hdr_byte[4:0], b};
            pred_sel = hdr_byte[7:5];
            if (cfg_coding_type == adfd_pkg::CODING_EXP) begin
                if (field > adfd_pkg::EXP_FIELD_MAX) field = adfd_pkg::EXP_FIELD_MAX;
                frame_gain = 14'd1 << (adfd_pkg::EXP_FIELD_MAX - field);
            end else begin
                frame_gain = {1'b0, field} + 14'd1;
            end
        end else begin
            decode_nibble(b[7:4], made_hi, s_hi);
            decode_nibble(b[3:0], made_lo, s_lo);
            if (made_hi) begin
                res.pcm  = s_hi;
                res.last = !made_lo;
                pcm_expected.push_back(res);
            end
            if (made_lo) begin
                res.pcm  = s_lo;
                res.last = 1'b1;
                pcm_expected.push_back(res);
            end
        end
        frame_pos = (frame_pos + 1 >= fs) ? 0 : frame_pos + 1;
    endtask

    task automatic report_error(input string what, input string want_s, input string got_s);
        error_count++;
        $display("%0t: %s: expected %s, actual %s", $time, what, want_s, got_s);
    endtask

    // Monitor: predict accepted bytes, check delivered samples
    always @(posedge i_clk) begin : monitor
        t_pcm_result want;
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire) begin
            predict_byte(i_data_byte);
            sent_count++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pcm_expected.size() == 0) begin
                report_error("sample with nothing pending", "none",
                             $sformatf("%0d", o_pcm_sample));
            end else begin
                want = pcm_expected.pop_front();
                if (o_pcm_sample !== want.pcm)
                    report_error("pcm_sample", $sformatf("%0d", want.pcm),
                                 $sformatf("%0d", o_pcm_sample));
                if (o_last_of_byte !== want.last)
                    report_error("last_of_byte", $sformatf("%0d", want.last),
                                 $sformatf("%0d", o_last_of_byte));
            end
        end
    end

    // Driver: feed bytes from the queue, hold for gaps and drain points
    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_fire) begin
                if (sent_count == drain_at && pcm_expected.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else if (in_gap > 0) begin
                    i_in_valid <= 1'b0;
                    in_gap--;
                end else if (byte_queue.size() != 0) begin
                    i_data_byte <= byte_queue.pop_front();
                    i_in_valid  <= 1'b1;
                    in_gap = idle_on ? pick_gap() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            // Stall the result side in bursts
            if (out_hold > 0) begin
                i_out_stall <= 1'b1;
                out_hold--;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_hold = pick_gap();
                i_out_stall <= (out_hold > 0);
                if (out_hold > 0) out_hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Write one register and mirror it once the transaction completes
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            adfd_pkg::REG_FRAME_SIZE:       cfg_frame_size   = value[7:0];
            adfd_pkg::REG_CODING_TYPE:      cfg_coding_type  = value[1:0];
            adfd_pkg::REG_EXACT_PREDICTION: cfg_exact        = value[0];
            adfd_pkg::REG_START_HISTORY: begin
                hist_recent = value[15:0];
                hist_older  = value[15:0];
            end
            adfd_pkg::REG_SAMPLE_COUNT:     cfg_sample_count = value;
            adfd_pkg::REG_SKIP_COUNT:       cfg_skip_count   = value;
            adfd_pkg::REG_COEF_FIRST:       cfg_coef_first   = value[15:0];
            adfd_pkg::REG_COEF_SECOND:      cfg_coef_second  = value[15:0];
            default: ;
        endcase
    endtask

    // Set unused upper data bits at random when asked
    function automatic logic [31:0] with_noise(input logic [31:0] v, input int width,
                                               input bit dirty);
        return dirty ? (v | ($urandom << width)) : v;
    endfunction

    task automatic program_regs(input logic [7:0] fs, input logic [1:0] ct, input logic ex,
                                input logic [15:0] sh, input logic [31:0] sc,
                                input logic [31:0] sk, input logic [15:0] c1,
                                input logic [15:0] c2, input bit dirty);
        write_reg(adfd_pkg::REG_FRAME_SIZE,       with_noise({24'd0, fs}, 8, dirty));
        write_reg(adfd_pkg::REG_CODING_TYPE,      with_noise({30'd0, ct}, 2, dirty));
        write_reg(adfd_pkg::REG_EXACT_PREDICTION, with_noise({31'd0, ex}, 1, dirty));
        write_reg(adfd_pkg::REG_START_HISTORY,    with_noise({16'd0, sh}, 16, dirty));
        write_reg(adfd_pkg::REG_SAMPLE_COUNT,     sc);
        write_reg(adfd_pkg::REG_SKIP_COUNT,       sk);
        write_reg(adfd_pkg::REG_COEF_FIRST,       with_noise({16'd0, c1}, 16, dirty));
        write_reg(adfd_pkg::REG_COEF_SECOND,      with_noise({16'd0, c2}, 16, dirty));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for the stream to drain, then let the pipeline empty
    task automatic settle();
        while (byte_queue.size() != 0 || i_in_valid || pcm_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          n_bytes, pos, fs_eff, random_sent, r, i;
        logic [7:0]  b, fs;
        logic [1:0]  ct;
        logic        ex;
        logic [15:0] sh, c1, c2;
        logic [31:0] sc, sk;
        bit          framed, dirty;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Linear scale, nibble extremes
        program_regs(8'd5, adfd_pkg::CODING_LINEAR, 1'b1, 16'h0000,
                     emitted_cnt + 32'd100, 32'd0, 16'h0f00, 16'h0000, 1'b0);
        byte_queue.push_back(8'h00); byte_queue.push_back(8'h00);
        byte_queue.push_back(8'h7F); byte_queue.push_back(8'h80);
        byte_queue.push_back(8'h08);
        settle();

        // Fixed table, short frame size, per-tap rounding, out-of-range row
        program_regs(8'd0, adfd_pkg::CODING_FIXED, 1'b0, 16'h0100,
                     emitted_cnt + 32'd100, 32'd0, 16'h0000, 16'h0000, 1'b0);
        byte_queue.push_back(8'hE0); byte_queue.push_back(8'h01); byte_queue.push_back(8'h9A);
        byte_queue.push_back(8'h40); byte_queue.push_back(8'h03); byte_queue.push_back(8'h12);
        byte_queue.push_back(8'h20); byte_queue.push_back(8'h00); byte_queue.push_back(8'hF5);
        settle();

        // Exponential scale at and above the field cap, extreme coefficients
        program_regs(8'd3, adfd_pkg::CODING_EXP, 1'b0, 16'h8000,
                     emitted_cnt + 32'd100, 32'd0, 16'h7fff, 16'h8000, 1'b0);
        byte_queue.push_back(8'h00); byte_queue.push_back(8'h0C); byte_queue.push_back(8'h77);
        byte_queue.push_back(8'h1F); byte_queue.push_back(8'hFF); byte_queue.push_back(8'h88);
        byte_queue.push_back(8'h00); byte_queue.push_back(8'h00); byte_queue.push_back(8'h7F);
        settle();

        // Unused type, largest gain, padding then the sample limit
        program_regs(8'd4, CODING_UNUSED, 1'b1, 16'h7fff, emitted_cnt + 32'd3,
                     stream_pos + 32'd3, 16'h8000, 16'h7fff, 1'b0);
        byte_queue.push_back(8'hFF); byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h12); byte_queue.push_back(8'h34);
        byte_queue.push_back(8'h00); byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hAB); byte_queue.push_back(8'hCD);
        settle();

        // Random phases
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            r  = $urandom_range(0, 19);
            fs = (r == 0) ? 8'($urandom_range(0, 2)) :
                 (r == 1) ? 8'd255 :
                 (r == 2) ? 8'd3 : 8'($urandom_range(4, 20));
            ct = 2'($urandom_range(0, 3));
            ex = 1'($urandom_range(0, 1));
            r  = $urandom_range(0, 9);
            sh = (r == 0) ? 16'h8000 :
                 (r == 1) ? 16'h7fff :
                 (r < 5)  ? 16'($urandom) : 16'($urandom_range(0, 2047)) - 16'd1024;
            r  = $urandom_range(0, 9);
            sc = (r == 0) ? emitted_cnt + 32'($urandom_range(0, 10)) :
                 (r == 1) ? 32'hFFFF_FFFF : emitted_cnt + 32'd1000;
            r  = $urandom_range(0, 19);
            sk = (r < 3)  ? stream_pos + 32'($urandom_range(1, 12)) :
                 (r == 3) ? 32'd0 :
                 (r == 4) ? 32'hFFFF_FFFF : stream_pos;
            r  = $urandom_range(0, 9);
            if (r == 0) begin
                c1 = 16'h7fff; c2 = 16'h8000;
            end else if (r == 1) begin
                c1 = 16'h8000; c2 = 16'h7fff;
            end else if (r < 4) begin
                c1 = 16'($urandom); c2 = 16'($urandom);
            end else begin
                c1 = 16'($urandom_range(0, 16'h1fff));
                c2 = -16'($urandom_range(0, 16'h1000));
            end
            dirty = ($urandom_range(0, 3) == 0);
            program_regs(fs, ct, ex, sh, sc, sk, c1, c2, dirty);

            n_bytes  = $urandom_range(25, 50);
            framed   = ($urandom_range(0, 4) != 0);
            idle_on  = ($urandom_range(0, 3) != 0);
            drain_at = (random_sent == 0 || $urandom_range(0, 2) == 0) ?
                       sent_count + n_bytes / 2 : -1;

            // Build frames with plausible headers, or plain noise
            fs_eff = (cfg_frame_size < adfd_pkg::MIN_FRAME_SIZE) ?
                     adfd_pkg::MIN_FRAME_SIZE : cfg_frame_size;
            pos    = frame_pos;
            for (i = 0; i < n_bytes; i++) begin
                if (!framed || pos > 1 || $urandom_range(0, 4) == 0)
                    b = 8'($urandom);
                else if (pos == 0)
                    b = {3'($urandom), 5'd0};
                else if (cfg_coding_type == adfd_pkg::CODING_EXP || $urandom_range(0, 1) == 0)
                    b = 8'($urandom_range(0, 15));
                else
                    b = 8'($urandom);
                byte_queue.push_back(b);
                pos = (pos + 1 >= fs_eff) ? 0 : pos + 1;
            end
            random_sent += n_bytes;
            settle();
        end

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
sv/adfd_pkg.sv
sv/adfd_cfg_regs.sv
sv/adfd_nibble_dp.sv
sv/adpcm_4bit_frame_decoder.sv
sv/adfd_checker.sv
dv/testbench.sv
